### hdl/scd_pkg.sv
// Shared types, codes and keymap tables for the scancode decoder.
// No dependencies; used by scd_keymap, scd_decode and the top level.
package scd_pkg;

	localparam int unsigned CODE_W = 8;
	localparam int unsigned KEY_W  = 7;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned LAYOUT_W = 2;

	localparam logic [LAYOUT_W-1:0] LAYOUT_QWERTY = 2'd0;
	localparam logic [LAYOUT_W-1:0] LAYOUT_QWERTZ = 2'd1;
	localparam logic [LAYOUT_W-1:0] LAYOUT_AZERTY = 2'd2;

	localparam logic [CODE_W-1:0] PREFIX_CODE = 8'hE0;
	localparam logic [KEY_W-1:0]  KEY_CTRL    = 7'h1D;
	localparam logic [KEY_W-1:0]  KEY_ALT     = 7'h38;
	localparam logic [KEY_W-1:0]  KEY_LSHIFT  = 7'h2A;
	localparam logic [KEY_W-1:0]  KEY_RSHIFT  = 7'h36;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_L = 7'h6C;

	typedef struct packed {
		logic              hit;
		logic [CHAR_W-1:0] plain;
		logic [CHAR_W-1:0] shifted;
	} patch_t;

	typedef struct packed {
		logic              char_valid;
		logic [CHAR_W-1:0] char_code;
		logic              clear_request;
		logic              shift_down;
		logic              ctrl_down;
		logic              alt_down;
	} res_t;

	// US base map, unshifted
	function automatic logic [CHAR_W-1:0] base_plain(input logic [KEY_W-1:0] key);
		logic [CHAR_W-1:0] v;
		v = '0;
		unique case (key)
			7'd1:  v = 7'h1B;
			7'd2:  v = 7'h31;
			7'd3:  v = 7'h32;
			7'd4:  v = 7'h33;
			7'd5:  v = 7'h34;
			7'd6:  v = 7'h35;
			7'd7:  v = 7'h36;
			7'd8:  v = 7'h37;
			7'd9:  v = 7'h38;
			7'd10: v = 7'h39;
			7'd11: v = 7'h30;
			7'd12: v = 7'h2D;
			7'd13: v = 7'h3D;
			7'd14: v = 7'h08;
			7'd15: v = 7'h09;
			7'd16: v = 7'h71;
			7'd17: v = 7'h77;
			7'd18: v = 7'h65;
			7'd19: v = 7'h72;
			7'd20: v = 7'h74;
			7'd21: v = 7'h79;
			7'd22: v = 7'h75;
			7'd23: v = 7'h69;
			7'd24: v = 7'h6F;
			7'd25: v = 7'h70;
			7'd26: v = 7'h5B;
			7'd27: v = 7'h5D;
			7'd28: v = 7'h0A;
			7'd30: v = 7'h61;
			7'd31: v = 7'h73;
			7'd32: v = 7'h64;
			7'd33: v = 7'h66;
			7'd34: v = 7'h67;
			7'd35: v = 7'h68;
			7'd36: v = 7'h6A;
			7'd37: v = 7'h6B;
			7'd38: v = 7'h6C;
			7'd39: v = 7'h3B;
			7'd40: v = 7'h27;
			7'd41: v = 7'h60;
			7'd43: v = 7'h5C;
			7'd44: v = 7'h7A;
			7'd45: v = 7'h78;
			7'd46: v = 7'h63;
			7'd47: v = 7'h76;
			7'd48: v = 7'h62;
			7'd49: v = 7'h6E;
			7'd50: v = 7'h6D;
			7'd51: v = 7'h2C;
			7'd52: v = 7'h2E;
			7'd53: v = 7'h2F;
			7'd55: v = 7'h2A;
			7'd57: v = 7'h20;
			7'd74: v = 7'h2D;
			7'd78: v = 7'h2B;
			default: v = '0;
		endcase
		return v;
	endfunction

	// US base map, shifted
	function automatic logic [CHAR_W-1:0] base_shifted(input logic [KEY_W-1:0] key);
		logic [CHAR_W-1:0] v;
		v = '0;
		unique case (key)
			7'd1:  v = 7'h1B;
			7'd2:  v = 7'h21;
			7'd3:  v = 7'h40;
			7'd4:  v = 7'h23;
			7'd5:  v = 7'h24;
			7'd6:  v = 7'h25;
			7'd7:  v = 7'h5E;
			7'd8:  v = 7'h26;
			7'd9:  v = 7'h2A;
			7'd10: v = 7'h28;
			7'd11: v = 7'h29;
			7'd12: v = 7'h5F;
			7'd13: v = 7'h2B;
			7'd14: v = 7'h08;
			7'd15: v = 7'h09;
			7'd16: v = 7'h51;
			7'd17: v = 7'h57;
			7'd18: v = 7'h45;
			7'd19: v = 7'h52;
			7'd20: v = 7'h54;
			7'd21: v = 7'h59;
			7'd22: v = 7'h55;
			7'd23: v = 7'h49;
			7'd24: v = 7'h4F;
			7'd25: v = 7'h50;
			7'd26: v = 7'h7B;
			7'd27: v = 7'h7D;
			7'd28: v = 7'h0A;
			7'd30: v = 7'h41;
			7'd31: v = 7'h53;
			7'd32: v = 7'h44;
			7'd33: v = 7'h46;
			7'd34: v = 7'h47;
			7'd35: v = 7'h48;
			7'd36: v = 7'h4A;
			7'd37: v = 7'h4B;
			7'd38: v = 7'h4C;
			7'd39: v = 7'h3A;
			7'd40: v = 7'h22;
			7'd41: v = 7'h7E;
			7'd43: v = 7'h7C;
			7'd44: v = 7'h5A;
			7'd45: v = 7'h58;
			7'd46: v = 7'h43;
			7'd47: v = 7'h56;
			7'd48: v = 7'h42;
			7'd49: v = 7'h4E;
			7'd50: v = 7'h4D;
			7'd51: v = 7'h3C;
			7'd52: v = 7'h3E;
			7'd53: v = 7'h3F;
			7'd55: v = 7'h2A;
			7'd57: v = 7'h20;
			7'd74: v = 7'h2D;
			7'd78: v = 7'h2B;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Per-layout overrides on top of the base map
	function automatic patch_t layout_patch(input logic [LAYOUT_W-1:0] layout,
			input logic [KEY_W-1:0] key);
		patch_t p;
		p = '0;
		if (layout == LAYOUT_QWERTZ) begin
			case (key)
				7'd21: p = '{1'b1, 7'h7A, 7'h5A};
				7'd44: p = '{1'b1, 7'h79, 7'h59};
				default: p = '0;
			endcase
		end else if (layout == LAYOUT_AZERTY) begin
			// accented keys fold to plain letters
			case (key)
				7'd2:  p = '{1'b1, 7'h26, 7'h31};
				7'd3:  p = '{1'b1, 7'h65, 7'h32};
				7'd4:  p = '{1'b1, 7'h22, 7'h33};
				7'd5:  p = '{1'b1, 7'h27, 7'h34};
				7'd6:  p = '{1'b1, 7'h28, 7'h35};
				7'd7:  p = '{1'b1, 7'h2D, 7'h36};
				7'd8:  p = '{1'b1, 7'h65, 7'h37};
				7'd9:  p = '{1'b1, 7'h5F, 7'h38};
				7'd10: p = '{1'b1, 7'h63, 7'h39};
				7'd11: p = '{1'b1, 7'h61, 7'h30};
				7'd12: p = '{1'b1, 7'h29, 7'h00};
				7'd13: p = '{1'b1, 7'h3D, 7'h2B};
				7'd16: p = '{1'b1, 7'h61, 7'h41};
				7'd17: p = '{1'b1, 7'h7A, 7'h5A};
				7'd30: p = '{1'b1, 7'h71, 7'h51};
				7'd39: p = '{1'b1, 7'h6D, 7'h4D};
				7'd40: p = '{1'b1, 7'h23, 7'h23};
				7'd41: p = '{1'b1, 7'h24, 7'h2A};
				7'd43: p = '{1'b1, 7'h3C, 7'h3E};
				7'd44: p = '{1'b1, 7'h77, 7'h57};
				7'd50: p = '{1'b1, 7'h2C, 7'h3F};
				7'd51: p = '{1'b1, 7'h3B, 7'h2E};
				7'd52: p = '{1'b1, 7'h3A, 7'h2F};
				7'd53: p = '{1'b1, 7'h21, 7'h00};
				default: p = '0;
			endcase
		end
		return p;
	endfunction

endpackage

### hdl/scancode_to_ascii_decoder.sv
// Set 1 scancode to ASCII decoder, top level.
// A request is captured in the input register (stage 1), then decoded into the result
// register (stage 2), which drives out_valid and the result outputs.
// Throughput: one request per cycle, except while in_stall holds a full stage 1 behind a stalled result.
// Input and result registers decouple the channels; a new request is taken
// while a finished result waits on out_stall.
// Reset (arst_n low, async): held flags, prefix flag and layout clear to 0 (qwerty).
module scancode_to_ascii_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         layout_we,
	input  logic [scd_pkg::LAYOUT_W-1:0] layout_wdata,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [scd_pkg::CODE_W-1:0]   scancode,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         char_valid,
	output logic [scd_pkg::CHAR_W-1:0]   char_code,
	output logic                         clear_request,
	output logic                         shift_down,
	output logic                         ctrl_down,
	output logic                         alt_down
);

	logic [scd_pkg::LAYOUT_W-1:0] layout_q;

	// stage 1: captured request
	logic                       valid_s1;
	logic [scd_pkg::CODE_W-1:0] scancode_s1;

	// stage 2: result register
	logic          valid_s2;
	scd_pkg::res_t res_s2;

	scd_pkg::res_t res_d;
	logic          advance;  // stage 1 moves into the result register
	logic          accept;

	// Stage 1 drains when the result register is empty or being taken.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= scd_pkg::LAYOUT_QWERTY;
		end else if (layout_we) begin
			layout_q <= layout_wdata;
		end
	end

	// Flags update exactly once per request, when it leaves stage 1,
	// so the next request in stage 1 always sees the updated flags.
	scd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.scancode (scancode_s1),
		.layout   (layout_q),
		.res      (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scancode_s1 <= scancode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign char_valid    = res_s2.char_valid;
	assign char_code     = res_s2.char_code;
	assign clear_request = res_s2.clear_request;
	assign shift_down    = res_s2.shift_down;
	assign ctrl_down     = res_s2.ctrl_down;
	assign alt_down      = res_s2.alt_down;

endmodule

### hdl/scd_keymap.sv
// Key to ASCII lookup: base map plus per-layout overrides.
// Depends on scd_pkg tables.
module scd_keymap (
	input  logic [scd_pkg::LAYOUT_W-1:0] layout,
	input  logic [scd_pkg::KEY_W-1:0]    key,
	input  logic                         shifted,
	output logic [scd_pkg::CHAR_W-1:0]   entry
);

	scd_pkg::patch_t patch;
	logic [scd_pkg::CHAR_W-1:0] base;

	always_comb begin
		patch = scd_pkg::layout_patch(layout, key);
		base  = shifted ? scd_pkg::base_shifted(key) : scd_pkg::base_plain(key);
		if (patch.hit) begin
			entry = shifted ? patch.shifted : patch.plain;
		end else begin
			entry = base;
		end
	end

endmodule

### hdl/scd_decode.sv
// Modifier/prefix flag registers and per-code result decision.
// Depends on scd_pkg and scd_keymap.
module scd_decode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [scd_pkg::CODE_W-1:0]   scancode,
	input  logic [scd_pkg::LAYOUT_W-1:0] layout,
	output scd_pkg::res_t                res
);

	logic shift_q, ctrl_q, alt_q, ext_q;
	logic shift_d, ctrl_d, alt_d, ext_d;
	logic [scd_pkg::KEY_W-1:0]  key;
	logic [scd_pkg::CHAR_W-1:0] entry;
	logic rel, is_prefix, is_ctrl, is_alt, is_shift, is_plain;

	assign key = scancode[scd_pkg::KEY_W-1:0];
	assign rel = scancode[scd_pkg::CODE_W-1];

	scd_keymap u_keymap (
		.layout  (layout),
		.key     (key),
		.shifted (shift_q),
		.entry   (entry)
	);

	always_comb begin
		is_prefix = (scancode == scd_pkg::PREFIX_CODE);
		is_ctrl   = !is_prefix && (key == scd_pkg::KEY_CTRL);
		is_alt    = !is_prefix && !is_ctrl && (key == scd_pkg::KEY_ALT);
		is_shift  = !is_prefix && !is_ctrl && !is_alt && !ext_q &&
			(key == scd_pkg::KEY_LSHIFT || key == scd_pkg::KEY_RSHIFT);
		is_plain  = !is_prefix && !is_ctrl && !is_alt && !is_shift;

		shift_d = is_shift ? !rel : shift_q;
		ctrl_d  = is_ctrl  ? !rel : ctrl_q;
		alt_d   = is_alt   ? !rel : alt_q;
		if (is_prefix) begin
			ext_d = 1'b1;
		end else if (is_plain && rel) begin
			ext_d = 1'b0;
		end else begin
			ext_d = ext_q;
		end

		res.char_valid    = is_plain && !rel && (entry != '0);
		res.char_code     = res.char_valid ? entry : '0;
		res.clear_request = is_plain && ctrl_q && (entry == scd_pkg::CHAR_LOWER_L);
		res.shift_down    = shift_d;
		res.ctrl_down     = ctrl_d;
		res.alt_down      = alt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
			alt_q   <= 1'b0;
			ext_q   <= 1'b0;
		end else if (advance) begin
			shift_q <= shift_d;
			ctrl_q  <= ctrl_d;
			alt_q   <= alt_d;
			ext_q   <= ext_d;
		end
	end

endmodule
